### hw/rtl/anb_pkg.sv
// shared types and constants for the annex-b access unit splitter
package anb_pkg;

  localparam int WIN_SIZE = 5;
  localparam logic [2:0] WIN_FULL = 3'(WIN_SIZE);

  localparam logic [2:0] SC_NONE  = 3'd0;
  localparam logic [2:0] SC_SHORT = 3'd3;
  localparam logic [2:0] SC_LONG  = 3'd4;

  localparam logic [4:0] NAL_TYPE_MASK = 5'h1F;
  localparam logic [4:0] NAL_IDR = 5'd5;
  localparam logic [4:0] NAL_SPS = 5'd7;
  localparam logic [4:0] NAL_PPS = 5'd8;
  localparam logic [4:0] NAL_AUD = 5'd9;

  localparam logic [4:0] FLAG_SPS   = 5'b00001;
  localparam logic [4:0] FLAG_PPS   = 5'b00010;
  localparam logic [4:0] FLAG_IDR   = 5'b00100;
  localparam logic [4:0] FLAG_LONG  = 5'b01000;
  localparam logic [4:0] FLAG_SHORT = 5'b10000;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_LEAD   = 2'd1;
  localparam logic [1:0] ST_EMPTY_NAL = 2'd2;
  localparam logic [1:0] ST_NO_AUD    = 2'd3;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        au_start;
    logic        nal_start;
    logic        out_last;
    logic [1:0]  status;
    logic [4:0]  seen_flags;
    logic [15:0] first_idr_unit;
    logic        first_idr_valid;
  } result_t;

endpackage

### hw/rtl/anb_parse.sv
// look-ahead window, start code detection and stream state
module anb_parse #(
  parameter int UNIT_INDEX_BITS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      in_byte,
  input  logic            in_last,
  input  logic            res_ready,
  output logic            res_valid,
  output anb_pkg::result_t res
);
  import anb_pkg::*;

  logic [7:0]                 win [WIN_SIZE];
  logic [7:0]                 win_next [WIN_SIZE];
  logic [2:0]                 fill;
  logic [2:0]                 fill_pop;
  logic [2:0]                 skip;
  logic                       expect_header;
  logic                       seen_aud;
  logic [UNIT_INDEX_BITS-1:0] unit_count;
  logic [UNIT_INDEX_BITS-1:0] idr_index;
  logic                       idr_valid;
  logic [4:0]                 flags;
  logic [1:0]                 err;
  logic                       at_head;
  logic                       flushing;

  logic                       can_emit;
  logic                       emit_go;
  logic                       accept;
  logic                       last_e;
  logic [2:0]                 size;
  logic [7:0]                 hdr_byte;
  logic [4:0]                 nal_type;
  logic                       au;
  logic [2:0]                 skip_next;
  logic                       expect_next;
  logic                       seen_next;
  logic [UNIT_INDEX_BITS-1:0] unit_next;
  logic [UNIT_INDEX_BITS-1:0] idr_index_next;
  logic                       idr_valid_next;
  logic [4:0]                 flags_next;
  logic [1:0]                 err_next;
  logic [31:0]                idr_wide;

  assign can_emit  = (fill == WIN_FULL) || (flushing && fill != 3'd0);
  assign emit_go   = can_emit && res_ready;
  assign in_stall  = flushing || (fill == WIN_FULL && !emit_go);
  assign accept    = in_valid && !in_stall;
  assign last_e    = flushing && fill == 3'd1;
  assign res_valid = emit_go;
  assign fill_pop  = emit_go ? fill - 3'd1 : fill;

  // start code match and header decode for the oldest window byte
  always_comb begin
    size           = SC_NONE;
    hdr_byte       = '0;
    nal_type       = '0;
    au             = 1'b0;
    skip_next      = skip;
    expect_next    = expect_header;
    seen_next      = seen_aud;
    unit_next      = unit_count;
    idr_index_next = idr_index;
    idr_valid_next = idr_valid;
    flags_next     = flags;
    err_next       = err;

    if (skip != 3'd0) begin
      skip_next = skip - 3'd1;
    end else if (fill >= 3'd3 && win[0] == 8'h00 && win[1] == 8'h00) begin
      if (fill >= 3'd4 && win[2] == 8'h00 && win[3] == 8'h01) begin
        size = SC_LONG;
      end else if (win[2] == 8'h01) begin
        size = SC_SHORT;
      end
    end

    if (size != SC_NONE) begin
      skip_next  = size;
      flags_next = flags_next | ((size == SC_LONG) ? FLAG_LONG : FLAG_SHORT);
      if (at_head) begin
        au = 1'b1;
      end
      hdr_byte = (size == SC_LONG) ? win[4] : win[3];
      nal_type = hdr_byte[4:0] & NAL_TYPE_MASK;
      if (size < fill) begin
        if (nal_type == NAL_SPS) begin
          flags_next = flags_next | FLAG_SPS;
        end
        if (nal_type == NAL_PPS) begin
          flags_next = flags_next | FLAG_PPS;
        end
        if (nal_type == NAL_IDR) begin
          flags_next = flags_next | FLAG_IDR;
          if (!idr_valid) begin
            idr_index_next = unit_count;
            idr_valid_next = 1'b1;
          end
        end
        if (nal_type == NAL_AUD) begin
          if (seen_aud) begin
            if (unit_count != '1) begin
              unit_next = unit_count + UNIT_INDEX_BITS'(1);
            end
            au = 1'b1;
          end
          seen_next = 1'b1;
        end
      end else begin
        expect_next = 1'b1;
      end
    end

    if (at_head && size == SC_NONE && err == ST_OK) begin
      err_next = ST_NO_LEAD;
    end
    if (last_e) begin
      if (err_next == ST_OK && expect_next) begin
        err_next = ST_EMPTY_NAL;
      end
      if (err_next == ST_OK && !seen_next) begin
        err_next = ST_NO_AUD;
      end
    end
  end

  assign idr_wide = 32'(idr_index_next);

  always_comb begin
    res.out_byte        = win[0];
    res.au_start        = au;
    res.nal_start       = (size != SC_NONE);
    res.out_last        = last_e;
    res.status          = last_e ? err_next : ST_OK;
    res.seen_flags      = flags_next;
    res.first_idr_unit  = idr_valid_next ? idr_wide[15:0] : 16'd0;
    res.first_idr_valid = idr_valid_next;
  end

  // shift on emit, then write the new beat behind the remaining bytes
  always_comb begin
    for (int i = 0; i < WIN_SIZE - 1; i++) begin
      win_next[i] = emit_go ? win[i+1] : win[i];
    end
    win_next[WIN_SIZE-1] = win[WIN_SIZE-1];
    if (accept) begin
      for (int i = 0; i < WIN_SIZE; i++) begin
        if (3'(i) == fill_pop) begin
          win_next[i] = in_byte;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < WIN_SIZE; i++) begin
      win[i] <= win_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (emit_go && last_e)) begin
      fill          <= '0;
      skip          <= '0;
      expect_header <= 1'b0;
      seen_aud      <= 1'b0;
      unit_count    <= '0;
      idr_index     <= '0;
      idr_valid     <= 1'b0;
      flags         <= '0;
      err           <= ST_OK;
      at_head       <= 1'b1;
      flushing      <= 1'b0;
    end else begin
      fill <= accept ? fill_pop + 3'd1 : fill_pop;
      if (accept && in_last) begin
        flushing <= 1'b1;
      end
      if (emit_go) begin
        skip          <= skip_next;
        expect_header <= expect_next;
        seen_aud      <= seen_next;
        unit_count    <= unit_next;
        idr_index     <= idr_index_next;
        idr_valid     <= idr_valid_next;
        flags         <= flags_next;
        err           <= err_next;
        at_head       <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    emit_go && last_e |=> fill == 3'd0 && !flushing && at_head)
    else $error("stream end did not return to head state");

  a_flush_has_bytes: assert property (@(posedge clk) disable iff (rst)
    flushing |-> fill != 3'd0)
    else $error("draining with an empty window");

  a_flags_grow: assert property (@(posedge clk) disable iff (rst)
    emit_go && !last_e |=> (flags & $past(flags)) == $past(flags))
    else $error("seen flags lost a bit inside a stream");

  a_idr_held: assert property (@(posedge clk) disable iff (rst)
    idr_valid && !(emit_go && last_e) |=> idr_valid && $stable(idr_index))
    else $error("first idr index changed inside a stream");
`endif

endmodule

### hw/rtl/anb_out_reg.sv
// result register between the parser and the output channel
module anb_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              res_valid,
  input  anb_pkg::result_t  res,
  output logic              res_ready,
  output logic              out_valid,
  input  logic              out_stall,
  output anb_pkg::result_t  out_res
);
  import anb_pkg::*;

  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

endmodule

### hw/rtl/annexb_access_unit_splitter.sv
// top level of the annex-b access unit splitter
// a byte's result is taken into the result register once the five-byte window is full, or after the last beat
// sustained rate is one byte per cycle while out_stall is low, set by the window shift and the result register
// at stream end the window drains one result per cycle while out_stall is low, up to five, with input stalled
// rst is synchronous and clears all control state; the same clear follows every final result
module annexb_access_unit_splitter #(
  parameter int UNIT_INDEX_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        byte_valid,
  output logic        au_start,
  output logic        nal_start,
  output logic        out_last,
  output logic [1:0]  status,
  output logic [4:0]  seen_flags,
  output logic [15:0] first_idr_unit,
  output logic        first_idr_valid
);
  import anb_pkg::*;

  logic    res_valid;
  logic    res_ready;
  result_t res;
  result_t out_res;

  anb_parse #(
    .UNIT_INDEX_BITS(UNIT_INDEX_BITS)
  ) u_parse (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .res_ready(res_ready),
    .res_valid(res_valid),
    .res      (res)
  );

  anb_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .res_valid(res_valid),
    .res      (res),
    .res_ready(res_ready),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_res  (out_res)
  );

  assign out_byte        = out_res.out_byte;
  assign byte_valid      = 1'b1;
  assign au_start        = out_res.au_start;
  assign nal_start       = out_res.nal_start;
  assign out_last        = out_res.out_last;
  assign status          = out_res.status;
  assign seen_flags      = out_res.seen_flags;
  assign first_idr_unit  = out_res.first_idr_unit;
  assign first_idr_valid = out_res.first_idr_valid;

endmodule

### dv/testbench.sv
// self-checking testbench for the annex-b access unit splitter
`timescale 1ns / 100ps

module testbench;
  import anb_pkg::*;

  localparam int UNIT_BITS = 16;
  localparam longint unsigned UNIT_MAX = (64'd1 << UNIT_BITS) - 1;
  localparam int LIMIT = 2_000_000;
  localparam int STALL_PCT = 18;

  typedef struct {
    logic [7:0] data;
    logic       fin;
    bit         calm;
  } beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = 8'h00;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic        au_start;
  logic        nal_start;
  logic        out_last;
  logic [1:0]  status;
  logic [4:0]  seen_flags;
  logic [15:0] first_idr_unit;
  logic        first_idr_valid;

  beat_t      beat_q[$];
  logic [7:0] strm[$];
  result_t    parsed_q[$];
  bit         calm_now = 1'b0;

  int cycles = 0;
  int errors = 0;
  int streams = 0;
  int beats_in = 0;
  int checked = 0;

  // parser state
  logic [7:0]      win[5];
  int unsigned     fill;
  logic [2:0]      skip;
  bit              want_hdr;
  bit              aud_seen;
  bit              head;
  longint unsigned units;
  longint unsigned idr_at;
  bit              idr_ok;
  logic [4:0]      flags;
  logic [1:0]      err;

  annexb_access_unit_splitter #(.UNIT_INDEX_BITS(UNIT_BITS)) u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte), .in_last(in_last),
    .out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte),
    .byte_valid(byte_valid), .au_start(au_start), .nal_start(nal_start),
    .out_last(out_last), .status(status), .seen_flags(seen_flags),
    .first_idr_unit(first_idr_unit), .first_idr_valid(first_idr_valid)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic void clear_parser();
    foreach (win[i]) win[i] = 8'h00;
    fill = 0;
    skip = 3'd0;
    want_hdr = 1'b0;
    aud_seen = 1'b0;
    head = 1'b1;
    units = 0;
    idr_at = 0;
    idr_ok = 1'b0;
    flags = 5'd0;
    err = ST_OK;
  endfunction

  function automatic bit take_nal_header(logic [7:0] hdr);
    logic [4:0] kind;
    bit opens;
    kind = hdr[4:0] & NAL_TYPE_MASK;
    opens = 1'b0;
    if (kind == NAL_SPS) flags |= FLAG_SPS;
    if (kind == NAL_PPS) flags |= FLAG_PPS;
    if (kind == NAL_IDR) begin
      flags |= FLAG_IDR;
      if (!idr_ok) begin
        idr_at = units;
        idr_ok = 1'b1;
      end
    end
    if (kind == NAL_AUD) begin
      if (aud_seen) begin
        if (units < UNIT_MAX) units++;
        opens = 1'b1;
      end
      aud_seen = 1'b1;
    end
    return opens;
  endfunction

  function automatic void emit_byte(bit fin);
    result_t r;
    logic [7:0] b;
    logic [2:0] len;
    bit au;
    bit nal;
    b = win[0];
    len = SC_NONE;
    au = 1'b0;
    nal = 1'b0;
    if (skip != 3'd0) begin
      skip--;
    end else if (fill >= 3 && win[0] == 8'h00 && win[1] == 8'h00) begin
      if (fill >= 4 && win[2] == 8'h00 && win[3] == 8'h01) len = SC_LONG;
      else if (win[2] == 8'h01) len = SC_SHORT;
    end
    if (len != SC_NONE) begin
      nal = 1'b1;
      skip = len;
      flags |= (len == SC_LONG) ? FLAG_LONG : FLAG_SHORT;
      if (head) au = 1'b1;
      if (len < fill) au |= take_nal_header(win[len]);
      else want_hdr = 1'b1;
    end
    if (head && !nal && err == ST_OK) err = ST_NO_LEAD;
    head = 1'b0;
    for (int i = 0; i < 4; i++) win[i] = win[i+1];
    win[4] = 8'h00;
    fill--;
    r.status = ST_OK;
    if (fin) begin
      if (err == ST_OK && want_hdr) err = ST_EMPTY_NAL;
      if (err == ST_OK && !aud_seen) err = ST_NO_AUD;
      r.status = err;
    end
    r.out_byte = b;
    r.au_start = au;
    r.nal_start = nal;
    r.out_last = fin;
    r.seen_flags = flags;
    r.first_idr_unit = idr_ok ? idr_at[15:0] : 16'd0;
    r.first_idr_valid = idr_ok;
    parsed_q.insert(parsed_q.size(), r);
  endfunction

  function automatic void parse_beat(logic [7:0] data, logic fin);
    int n;
    n = 0;
    if (fill > 4) fill = 4;
    win[fill] = data;
    fill++;
    if (fin) begin
      while (fill > 0 && n < 5) begin
        emit_byte(fill == 1);
        n++;
      end
      clear_parser();
    end else if (fill == 5) begin
      emit_byte(1'b0);
    end
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("cycle %0d: %s got %0h want %0h", cycles, what, got, want);
    errors++;
  endtask

  task automatic check_result();
    result_t w;
    if (parsed_q.size() == 0) begin
      report_mismatch("result with nothing owed, byte", out_byte, 0);
      return;
    end
    w = parsed_q.pop_front();
    checked++;
    if (out_byte !== w.out_byte) report_mismatch("out_byte", out_byte, w.out_byte);
    if (byte_valid !== 1'b1) report_mismatch("byte_valid", byte_valid, 1);
    if (au_start !== w.au_start) report_mismatch("au_start", au_start, w.au_start);
    if (nal_start !== w.nal_start) report_mismatch("nal_start", nal_start, w.nal_start);
    if (out_last !== w.out_last) report_mismatch("out_last", out_last, w.out_last);
    if (status !== w.status) report_mismatch("status", status, w.status);
    if (seen_flags !== w.seen_flags) report_mismatch("seen_flags", seen_flags, w.seen_flags);
    if (first_idr_unit !== w.first_idr_unit)
      report_mismatch("first_idr_unit", first_idr_unit, w.first_idr_unit);
    if (first_idr_valid !== w.first_idr_valid)
      report_mismatch("first_idr_valid", first_idr_valid, w.first_idr_valid);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      clear_parser();
    end else begin
      if (in_valid && !in_stall) begin
        parse_beat(in_byte, in_last);
        beats_in++;
      end
      if (!in_valid || !in_stall) begin
        if (beat_q.size() != 0 && (beat_q[0].calm || $urandom_range(99) >= STALL_PCT)) begin
          in_valid <= 1'b1;
          in_byte <= beat_q[0].data;
          in_last <= beat_q[0].fin;
          calm_now <= beat_q[0].calm;
          void'(beat_q.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_result();
      out_stall <= calm_now ? 1'b0 : ($urandom_range(99) < STALL_PCT);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  function automatic void push_stream(bit calm);
    beat_t bt;
    foreach (strm[i]) begin
      bt.data = strm[i];
      bt.fin = (i == strm.size() - 1);
      bt.calm = calm;
      beat_q.insert(beat_q.size(), bt);
    end
    strm.delete();
    streams++;
  endfunction

  function automatic void put_byte(logic [7:0] b);
    strm.insert(strm.size(), b);
  endfunction

  function automatic void add_code(bit long_code);
    if (long_code) put_byte(8'h00);
    put_byte(8'h00);
    put_byte(8'h00);
    put_byte(8'h01);
  endfunction

  function automatic logic [7:0] rand_byte();
    int r;
    r = $urandom_range(9);
    if (r < 3) return 8'h00;
    if (r == 3) return 8'h01;
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] rand_header();
    logic [4:0] kind;
    case ($urandom_range(5))
      0: kind = NAL_AUD;
      1: kind = NAL_SPS;
      2: kind = NAL_PPS;
      3: kind = NAL_IDR;
      default: kind = 5'($urandom_range(31));
    endcase
    return {3'($urandom_range(7)), kind};
  endfunction

  initial begin
    int rand_beats;
    int nals;
    int cut;
    rand_beats = 0;

    // lone byte, bare short code, full unit sequence ending in a partial code, no delimiter
    strm = '{8'h5A};
    push_stream(1'b0);
    strm = '{8'h00, 8'h00, 8'h01};
    push_stream(1'b0);
    strm = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h09, 8'h00, 8'h00, 8'h01, 8'h67, 8'h00, 8'h00,
             8'h01, 8'h68, 8'h00, 8'h00, 8'h01, 8'h65, 8'h00, 8'h00, 8'h01, 8'h29, 8'hFF,
             8'h00, 8'h00};
    push_stream(1'b0);
    strm = '{8'h00, 8'h00, 8'h01, 8'hE5};
    push_stream(1'b0);

    // back-to-back delimited units, run without any idling
    for (int i = 0; i < 8; i++) begin
      add_code(i[0]);
      put_byte({3'd0, NAL_AUD});
      put_byte(8'h11);
    end
    add_code(1'b1);
    put_byte({3'd3, NAL_IDR});
    put_byte(8'hC3);
    push_stream(1'b1);

    while (rand_beats < 100) begin
      if ($urandom_range(99) < 75) begin
        nals = $urandom_range(1, 5);
        for (int k = 0; k < nals; k++) begin
          add_code(1'($urandom_range(1)));
          put_byte(rand_header());
          repeat ($urandom_range(6)) put_byte(rand_byte());
        end
        if ($urandom_range(99) < 15) strm.delete(0);
        if ($urandom_range(99) < 20) begin
          cut = $urandom_range(3);
          while (cut > 0 && strm.size() > 1) begin
            void'(strm.pop_back());
            cut--;
          end
        end
      end else begin
        repeat ($urandom_range(1, 8)) put_byte(rand_byte());
      end
      rand_beats += strm.size();
      push_stream(1'b0);
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    while (beat_q.size() != 0 || in_valid) @(posedge clk);
    while (parsed_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    $display("summary: %0d streams, %0d bytes driven, %0d results checked", streams, beats_in,
             checked);
    $display("summary: includes a stretch with no idling and all error codes");
    if (errors == 0 && parsed_q.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
